// ===== hw/rtl/signed_floor_divide_modulo_top_defines.svh =====
// ----------------------------------------------------------------------------
// Signed floor divide/modulo assertion macros
// Shared assertion wrappers for the floor divide/modulo block.
// ----------------------------------------------------------------------------
`ifndef SIGNED_FLOOR_DIVIDE_MODULO_TOP_DEFINES_SVH
`define SIGNED_FLOOR_DIVIDE_MODULO_TOP_DEFINES_SVH

// Check a property outside reset.
`define SFDM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a property at every edge, reset included.
`define SFDM_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== hw/rtl/sfdm_pkg.sv =====
// ----------------------------------------------------------------------------
// Signed floor divide/modulo package
// Request and response types and operation codes.
// ----------------------------------------------------------------------------
package sfdm_pkg;

  localparam int unsigned DataW = 64;

  localparam logic FUNC_QUO = 1'b0;
  localparam logic FUNC_MOD = 1'b1;

  typedef struct packed {
    logic                    func;
    logic signed [DataW-1:0] dividend;
    logic signed [DataW-1:0] divisor;
  } sfdm_req_t;

  typedef struct packed {
    logic signed [DataW-1:0] result;
    logic                    divide_by_zero;
  } sfdm_rsp_t;

endpackage

// ===== hw/rtl/signed_floor_divide_modulo_top.sv =====
// ----------------------------------------------------------------------------
// Signed floor divide/modulo
// Pipelined signed division with floor quotient or floor modulo output.
// ----------------------------------------------------------------------------
// A request is taken on every cycle that start is high; busy never rises.
// Each request produces one response on rsp_o, flagged by done_o for one
// cycle, in request order. The pipeline is a restoring divider that
// resolves one quotient bit per pipeline stage (WIDTH stages), plus one
// stage for sign/magnitude conversion and two for the floor correction.
// Operands use their low WIDTH bits; the result is sign-extended to 64
// bits. A zero divisor returns zero with divide_by_zero set. The consumer
// cannot stall, so results must be taken when done_o is high.
// ----------------------------------------------------------------------------
`include "signed_floor_divide_modulo_top_defines.svh"

module signed_floor_divide_modulo_top #(
  parameter int unsigned WIDTH = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  sfdm_pkg::sfdm_req_t req_i,
  output logic              done_o,
  output sfdm_pkg::sfdm_rsp_t rsp_o
);
  import sfdm_pkg::*;

  typedef struct packed {
    logic func;
    logic neg_a;
    logic neg_b;
    logic zero;
  } meta_t;

  assign busy = 1'b0;

  // --------------------------------------------------------------------------
  // Stage 0: sign split and magnitudes
  // --------------------------------------------------------------------------
  logic [WIDTH-1:0] op_a, op_b, mag_a, mag_b;
  meta_t            meta_in;

  always_comb begin
    op_a          = req_i.dividend[WIDTH-1:0];
    op_b          = req_i.divisor[WIDTH-1:0];
    meta_in.func  = req_i.func;
    meta_in.neg_a = op_a[WIDTH-1];
    meta_in.neg_b = op_b[WIDTH-1];
    meta_in.zero  = (op_b == '0);
    mag_a         = meta_in.neg_a ? (~op_a + 1'b1) : op_a;
    mag_b         = meta_in.neg_b ? (~op_b + 1'b1) : op_b;
  end

  logic             vld_q  [0:WIDTH];
  meta_t            meta_q [0:WIDTH];
  logic [WIDTH-1:0] rem_q  [0:WIDTH];
  logic [WIDTH-1:0] dvd_q  [0:WIDTH];
  logic [WIDTH-1:0] magb_q [0:WIDTH];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else begin
      vld_q[0] <= start;
    end
  end

  always_ff @(posedge clk_i) begin
    meta_q[0] <= meta_in;
    rem_q[0]  <= '0;
    dvd_q[0]  <= mag_a;
    magb_q[0] <= mag_b;
  end

  // --------------------------------------------------------------------------
  // Divider: one quotient bit per stage
  // --------------------------------------------------------------------------
  for (genvar k = 0; k < WIDTH; k++) begin : g_div
    logic [WIDTH-1:0] shift;
    logic [WIDTH:0]   diff;
    logic             qbit;

    // Remainder stays below the divisor, so the shifted value fits WIDTH bits.
    always_comb begin
      shift = {rem_q[k][WIDTH-2:0], dvd_q[k][WIDTH-1]};
      diff  = {1'b0, shift} - {1'b0, magb_q[k]};
      qbit  = ~diff[WIDTH];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else begin
        vld_q[k+1] <= vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      meta_q[k+1] <= meta_q[k];
      magb_q[k+1] <= magb_q[k];
      rem_q[k+1]  <= qbit ? diff[WIDTH-1:0] : shift;
      dvd_q[k+1]  <= {dvd_q[k][WIDTH-2:0], qbit};
    end
  end

  // --------------------------------------------------------------------------
  // Post stage 1: floor quotient, remainder magnitude
  // --------------------------------------------------------------------------
  logic [WIDTH-1:0] quo_d, rmod_d;
  logic             differ, rem_nz;

  always_comb begin
    differ = meta_q[WIDTH].neg_a ^ meta_q[WIDTH].neg_b;
    rem_nz = (rem_q[WIDTH] != '0);
    // Truncated quotient negated, minus one when inexact: ~q covers both.
    if (!differ) begin
      quo_d = dvd_q[WIDTH];
    end else if (rem_nz) begin
      quo_d = ~dvd_q[WIDTH];
    end else begin
      quo_d = ~dvd_q[WIDTH] + 1'b1;
    end
    rmod_d = (differ && rem_nz) ? (magb_q[WIDTH] - rem_q[WIDTH]) : rem_q[WIDTH];
  end

  logic             p1_vld_q;
  meta_t            p1_meta_q;
  logic [WIDTH-1:0] p1_quo_q, p1_rmod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_vld_q <= 1'b0;
    end else begin
      p1_vld_q <= vld_q[WIDTH];
    end
  end

  always_ff @(posedge clk_i) begin
    p1_meta_q <= meta_q[WIDTH];
    p1_quo_q  <= quo_d;
    p1_rmod_q <= rmod_d;
  end

  // --------------------------------------------------------------------------
  // Post stage 2: modulo sign, select, output register
  // --------------------------------------------------------------------------
  logic signed [WIDTH-1:0] res_w;
  logic        [WIDTH-1:0] mod_w;
  sfdm_rsp_t               rsp_d;

  always_comb begin
    // Modulo takes the divisor's sign.
    mod_w = p1_meta_q.neg_b ? (~p1_rmod_q + 1'b1) : p1_rmod_q;
    if (p1_meta_q.zero) begin
      res_w = '0;
    end else if (p1_meta_q.func == FUNC_MOD) begin
      res_w = signed'(mod_w);
    end else begin
      res_w = signed'(p1_quo_q);
    end
    rsp_d.result         = DataW'(res_w);
    rsp_d.divide_by_zero = p1_meta_q.zero;
  end

  logic      done_q;
  sfdm_rsp_t rsp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= p1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  logic rem_ok;

  assign rem_ok = meta_q[WIDTH].zero || (rem_q[WIDTH] < magb_q[WIDTH]);

  `SFDM_ASSERT(a_div_to_post, vld_q[WIDTH] |=> p1_vld_q, "divider output lost")
  `SFDM_ASSERT(a_post_to_out, p1_vld_q |=> done_o, "response strobe missing")
  `SFDM_ASSERT(a_rem_bound, vld_q[WIDTH] |-> rem_ok, "remainder not below divisor")
  `SFDM_ASSERT_ALWAYS(a_dbz_zero, done_o && rsp_o.divide_by_zero |-> rsp_o.result == '0, "dbz")

endmodule
